// ===== rtl/tilt_to_stick_command_mapper_macros.svh =====
// assertion helpers used by the top-level mapper
`ifndef TILT_TO_STICK_COMMAND_MAPPER_MACROS_SVH
`define TILT_TO_STICK_COMMAND_MAPPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsc check failed");

// next-cycle implication, checked out of reset
`define TSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsc check failed");

`endif

// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

  localparam int Q_W   = 8;
  localparam int REM_W = 26;
  localparam int DSH_W = 24;
  localparam int NCELL = Q_W;

  localparam logic [REM_W-1:0] SCALE2       = REM_W'(200);
  localparam logic [14:0]      TILT_FLOOR   = 15'd100;
  localparam logic [18:0]      YAW_DEADBAND = 19'd500;
  localparam logic [REM_W-1:0] YAW_FULL     = REM_W'(6000);
  localparam logic [DSH_W-1:0] YAW_DSH      = DSH_W'(6000 * 2 * (1 << (Q_W - 1)));
  localparam logic [6:0]       CMD_LIMIT    = 7'd100;

  localparam logic REG_DEADZONE = 1'b0;
  localparam logic REG_MAX_TILT = 1'b1;

  typedef enum logic [2:0] {
    HEAD_HOVER    = 3'd0,
    HEAD_FORWARD  = 3'd1,
    HEAD_BACKWARD = 3'd2,
    HEAD_LEFT     = 3'd3,
    HEAD_RIGHT    = 3'd4
  } heading_t;

  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [REM_W-1:0] rem;
    logic [DSH_W-1:0] dsh;
    logic [Q_W-1:0]   q;
  } lane_t;

  typedef struct packed {
    lane_t pitch;
    lane_t roll;
    lane_t yaw;
  } axes_t;

  typedef struct packed {
    logic signed [7:0] pitch_cmd;
    logic signed [7:0] roll_cmd;
    logic signed [7:0] yaw_cmd;
    heading_t          heading;
    logic              neutral;
  } result_t;

  // one restoring division step
  function automatic lane_t lane_step(lane_t l);
    lane_t s;
    logic  ge;
    ge    = l.rem >= REM_W'(l.dsh);
    s     = l;
    if (ge) begin
      s.rem = l.rem - REM_W'(l.dsh);
    end
    s.dsh = l.dsh >> 1;
    s.q   = {l.q[Q_W-2:0], ge};
    return s;
  endfunction

  // saturated magnitude after the last step
  function automatic logic [6:0] lane_mag(lane_t l);
    logic [6:0] m;
    if (l.zero) begin
      m = 7'd0;
    end else if (l.q[Q_W-1] || (l.q[6:0] > CMD_LIMIT)) begin
      m = CMD_LIMIT;
    end else begin
      m = l.q[6:0];
    end
    return m;
  endfunction

endpackage

// ===== rtl/tsc_intf.sv =====
interface tsc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_cdeg;
  logic signed [15:0] roll_cdeg;
  logic signed [18:0] yaw_rate_cdps;

  modport source(output valid, output pitch_cdeg, output roll_cdeg, output yaw_rate_cdps,
                 input ready);
  modport sink(input valid, input pitch_cdeg, input roll_cdeg, input yaw_rate_cdps,
               output ready);
endinterface

interface tsc_cmd_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] pitch_cmd;
  logic signed [7:0] roll_cmd;
  logic signed [7:0] yaw_cmd;
  logic [2:0]        heading_class;
  logic              is_neutral;

  modport source(output valid, output pitch_cmd, output roll_cmd, output yaw_cmd,
                 output heading_class, output is_neutral, input ready);
  modport sink(input valid, input pitch_cmd, input roll_cmd, input yaw_cmd,
               input heading_class, input is_neutral, output ready);
endinterface

// ===== rtl/tsc_prep.sv =====
module tsc_prep (
  input  logic signed [15:0] pitch_cdeg,
  input  logic signed [15:0] roll_cdeg,
  input  logic signed [18:0] yaw_rate_cdps,
  input  logic [14:0]        deadzone_cdeg,
  input  logic [14:0]        max_tilt_cdeg,
  output tsc_pkg::axes_t     axes
);
  import tsc_pkg::*;

  logic [14:0] m;
  logic [15:0] pmag;
  logic [15:0] rmag;
  logic [18:0] ymag;

  assign m    = (max_tilt_cdeg < TILT_FLOOR) ? TILT_FLOOR : max_tilt_cdeg;
  assign pmag = pitch_cdeg[15] ? (~pitch_cdeg + 16'd1) : pitch_cdeg;
  assign rmag = roll_cdeg[15] ? (~roll_cdeg + 16'd1) : roll_cdeg;
  assign ymag = yaw_rate_cdps[18] ? (~yaw_rate_cdps + 19'd1) : yaw_rate_cdps;

  always_comb begin
    axes.pitch.zero = (pmag < {1'b0, deadzone_cdeg}) || (pmag == 16'd0);
    axes.pitch.neg  = pitch_cdeg[15];
    axes.pitch.rem  = REM_W'(pmag) * SCALE2 + REM_W'(m);
    axes.pitch.dsh  = DSH_W'({m, 1'b0, {(Q_W - 1){1'b0}}});
    axes.pitch.q    = '0;

    axes.roll.zero  = (rmag < {1'b0, deadzone_cdeg}) || (rmag == 16'd0);
    axes.roll.neg   = roll_cdeg[15];
    axes.roll.rem   = REM_W'(rmag) * SCALE2 + REM_W'(m);
    axes.roll.dsh   = DSH_W'({m, 1'b0, {(Q_W - 1){1'b0}}});
    axes.roll.q     = '0;

    axes.yaw.zero   = ymag < YAW_DEADBAND;
    axes.yaw.neg    = yaw_rate_cdps[18];
    axes.yaw.rem    = REM_W'(ymag) * SCALE2 + YAW_FULL;
    axes.yaw.dsh    = YAW_DSH;
    axes.yaw.q      = '0;
  end
endmodule

// ===== rtl/tsc_cell.sv =====
module tsc_cell (
  input  logic           clk,
  input  logic           rst,
  input  tsc_pkg::axes_t up_data,
  input  logic           up_valid,
  output logic           up_ready,
  output tsc_pkg::axes_t down_data,
  output logic           down_valid,
  input  logic           down_ready
);
  import tsc_pkg::*;

  axes_t data;
  logic  valid;

  assign up_ready = ~valid | down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= up_data;
    end
  end

  assign down_valid      = valid;
  assign down_data.pitch = lane_step(data.pitch);
  assign down_data.roll  = lane_step(data.roll);
  assign down_data.yaw   = lane_step(data.yaw);
endmodule

// ===== rtl/tsc_finish.sv =====
module tsc_finish (
  input  tsc_pkg::axes_t   axes,
  output tsc_pkg::result_t res
);
  import tsc_pkg::*;

  logic [6:0] ap;
  logic [6:0] ar;
  logic [6:0] ay;

  assign ap = lane_mag(axes.pitch);
  assign ar = lane_mag(axes.roll);
  assign ay = lane_mag(axes.yaw);

  always_comb begin
    res.pitch_cmd = axes.pitch.neg ? -$signed({1'b0, ap}) : $signed({1'b0, ap});
    res.roll_cmd  = axes.roll.neg ? -$signed({1'b0, ar}) : $signed({1'b0, ar});
    res.yaw_cmd   = axes.yaw.neg ? -$signed({1'b0, ay}) : $signed({1'b0, ay});
    res.neutral   = (ap == 7'd0) && (ar == 7'd0);
    if (res.neutral) begin
      res.heading = HEAD_HOVER;
    end else if (ap >= ar) begin
      res.heading = axes.pitch.neg ? HEAD_BACKWARD : HEAD_FORWARD;
    end else begin
      res.heading = axes.roll.neg ? HEAD_LEFT : HEAD_RIGHT;
    end
  end
endmodule

// ===== rtl/tilt_to_stick_command_mapper.sv =====
// Maps one attitude sample per beat to pitch, roll and yaw stick commands in percent
// plus a heading class. Fully pipelined: a new sample is taken every cycle while the
// output is not stalled. Each accepted sample loads the first of eight cells of a
// restoring divider chain, one cell per quotient bit, and the last cell feeds the
// output register. Back-pressure ripples back only through occupied cells. The user
// must write the deadzone and maximum tilt registers through the plain write port
// only while no sample is in flight; the block itself does not enforce this.
`include "tilt_to_stick_command_mapper_macros.svh"

module tilt_to_stick_command_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_wdata,
  tsc_sample_if.sink  sample,
  tsc_cmd_if.source   command
);
  import tsc_pkg::*;

  logic [14:0] deadzone_cdeg;
  logic [14:0] max_tilt_cdeg;

  axes_t   chain_data  [0:NCELL];
  logic    chain_valid [0:NCELL];
  logic    chain_ready [0:NCELL];
  result_t res;
  result_t out_data;
  logic    out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_cdeg <= 15'd500;
      max_tilt_cdeg <= 15'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADZONE: deadzone_cdeg <= cfg_wdata;
        REG_MAX_TILT: max_tilt_cdeg <= cfg_wdata;
      endcase
    end
  end

  tsc_prep u_prep (
    .pitch_cdeg    (sample.pitch_cdeg),
    .roll_cdeg     (sample.roll_cdeg),
    .yaw_rate_cdps (sample.yaw_rate_cdps),
    .deadzone_cdeg (deadzone_cdeg),
    .max_tilt_cdeg (max_tilt_cdeg),
    .axes          (chain_data[0])
  );

  assign chain_valid[0] = sample.valid;
  assign sample.ready   = chain_ready[0];

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    tsc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_data    (chain_data[k]),
      .up_valid   (chain_valid[k]),
      .up_ready   (chain_ready[k]),
      .down_data  (chain_data[k+1]),
      .down_valid (chain_valid[k+1]),
      .down_ready (chain_ready[k+1])
    );
  end

  tsc_finish u_finish (
    .axes (chain_data[NCELL]),
    .res  (res)
  );

  assign chain_ready[NCELL] = ~out_valid | command.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_ready[NCELL]) begin
      out_valid <= chain_valid[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[NCELL] && chain_valid[NCELL]) begin
      out_data <= res;
    end
  end

  assign command.valid         = out_valid;
  assign command.pitch_cmd     = out_data.pitch_cmd;
  assign command.roll_cmd      = out_data.roll_cmd;
  assign command.yaw_cmd       = out_data.yaw_cmd;
  assign command.heading_class = out_data.heading;
  assign command.is_neutral    = out_data.neutral;

  // intake only stalls behind a held result
  `TSC_ASSERT_NOW(a_stall_source, clk, rst, !sample.ready, command.valid && !command.ready)
  `TSC_ASSERT_NOW(a_neutral_match, clk, rst, command.valid,
    command.is_neutral == ((command.pitch_cmd == 8'sd0) && (command.roll_cmd == 8'sd0)))
  `TSC_ASSERT_NOW(a_hover_neutral, clk, rst, command.valid,
    (command.heading_class == HEAD_HOVER) == command.is_neutral)
  `TSC_ASSERT_NEXT(a_yaw_bound, clk, rst, chain_ready[NCELL] && chain_valid[NCELL],
    (command.yaw_cmd <= 8'sd100) && (command.yaw_cmd >= -8'sd100))
endmodule
